### hw/rtl/chol_pkg.sv
`default_nettype none

package chol_pkg;

    // Default largest matrix edge
    localparam int MAX_SIZE_DEF = 8;

    // Field widths
    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int IDX_W   = 3;
    localparam int SIZE_W  = 4;
    localparam int STAT_W  = 2;
    localparam int PADDR_W = 3;
    localparam int OP_W    = 4;

    // Arithmetic widths
    localparam int ACC_W  = 52;
    localparam int PROD_W = 2 * DATA_W;
    localparam int DIVN_W = DATA_W + FRAC_W;
    localparam int DIVD_W = 24;
    localparam int RAD_W  = DATA_W + FRAC_W;
    localparam int ROOT_W = RAD_W / 2;

    // Register map
    localparam logic REG_MATRIX_SIZE = 1'b0;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_SYM = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_PD  = 2'd2;

    // Datapath operations
    localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
    localparam logic [OP_W-1:0] OP_WR_IN    = 4'd1;
    localparam logic [OP_W-1:0] OP_PIV_LD   = 4'd2;
    localparam logic [OP_W-1:0] OP_ACC_LD   = 4'd3;
    localparam logic [OP_W-1:0] OP_MUL      = 4'd4;
    localparam logic [OP_W-1:0] OP_ACC_SUB  = 4'd5;
    localparam logic [OP_W-1:0] OP_DIV_GO   = 4'd6;
    localparam logic [OP_W-1:0] OP_DIV_TAKE = 4'd7;
    localparam logic [OP_W-1:0] OP_WR_OFF   = 4'd8;
    localparam logic [OP_W-1:0] OP_PIV_SUB  = 4'd9;
    localparam logic [OP_W-1:0] OP_SQRT_GO  = 4'd10;
    localparam logic [OP_W-1:0] OP_WR_DIAG  = 4'd11;
    localparam logic [OP_W-1:0] OP_OUT_DATA = 4'd12;
    localparam logic [OP_W-1:0] OP_OUT_ERR  = 4'd13;

    typedef struct packed {
        logic              rd_en;
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  a_row;
        logic [IDX_W-1:0]  a_col;
        logic [IDX_W-1:0]  b_row;
        logic [IDX_W-1:0]  b_col;
        logic [STAT_W-1:0] status;
        logic              last;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic sym_diff;
        logic piv_nonpos;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

### hw/rtl/chol_div.sv
`default_nettype none

module chol_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [chol_pkg::DIVN_W-1:0] dividend,
    input  logic [chol_pkg::DIVD_W-1:0] divisor,
    output logic                        done,
    output logic [chol_pkg::DIVN_W-1:0] quot
);
    import chol_pkg::*;

    localparam int CNT_W = $clog2(DIVN_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVN_W-1:0] q_reg;
    logic [DIVD_W-1:0] rem_reg;
    logic [DIVD_W-1:0] d_reg;

    logic [DIVD_W:0] rem_sh;
    logic [DIVD_W:0] diff;
    logic            fits;

    // Trial subtract of one quotient bit
    always_comb
    begin
        rem_sh = {rem_reg, q_reg[DIVN_W-1]};
        diff   = rem_sh - {1'b0, d_reg};
        fits   = rem_sh >= {1'b0, d_reg};
    end

    // Count iterations
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVN_W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Shift dividend out and quotient in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            d_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[DIVN_W-2:0], fits};
            rem_reg <= fits ? diff[DIVD_W-1:0] : rem_sh[DIVD_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

### hw/rtl/chol_sqrt.sv
`default_nettype none

module chol_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [chol_pkg::RAD_W-1:0] radicand,
    output logic                       done,
    output logic [chol_pkg::ROOT_W-1:0] root
);
    import chol_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W:0]   rem_reg;

    logic [ROOT_W+2:0] rem_sh;
    logic [ROOT_W+2:0] trial;
    logic [ROOT_W+2:0] diff;
    logic              fits;

    // Trial subtract for one root bit
    always_comb
    begin
        rem_sh = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
        trial  = {1'b0, root_reg, 2'b01};
        diff   = rem_sh - trial;
        fits   = rem_sh >= trial;
    end

    // Count iterations
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(ROOT_W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Take two radicand bits per step
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            root_reg <= {root_reg[ROOT_W-2:0], fits};
            rem_reg  <= fits ? diff[ROOT_W:0] : rem_sh[ROOT_W:0];
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

### hw/rtl/chol_dp.sv
`default_nettype none

module chol_dp #(
    parameter int MAX_SIZE = chol_pkg::MAX_SIZE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  chol_pkg::cmd_t                     cmd,
    output chol_pkg::sts_t                     sts,
    input  logic signed [chol_pkg::DATA_W-1:0] element_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [chol_pkg::DATA_W-1:0] factor_value,
    output logic [chol_pkg::IDX_W-1:0]         out_row,
    output logic [chol_pkg::IDX_W-1:0]         out_col,
    output logic [chol_pkg::STAT_W-1:0]        status,
    output logic                               last_result
);
    import chol_pkg::*;

    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;
    localparam logic [DIVN_W-1:0] Q_POS_MAX = DIVN_W'(32'h7FFF_FFFF);
    localparam logic [DIVN_W-1:0] Q_NEG_MAX = DIVN_W'(32'h8000_0000);
    localparam logic [DATA_W-1:0] W_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] W_MIN = 32'h8000_0000;

    logic [DATA_W-1:0] mem [DEPTH];

    logic [AW-1:0]     addr_a, addr_b;
    logic              we;
    logic [DATA_W-1:0] wdata;

    logic signed [DATA_W-1:0] rd_a_reg, rd_b_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  piv_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [DIVD_W-1:0]        diag_reg;
    logic                     neg_reg;
    logic signed [DATA_W-1:0] soff_reg;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] factor_reg;
    logic [IDX_W-1:0]         row_reg, col_reg;
    logic [STAT_W-1:0]        status_reg;
    logic                     last_reg;

    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_out;
    logic                     rnd;
    logic signed [ACC_W-1:0]  qprod;
    logic signed [DATA_W-1:0] acc_sat;
    logic [DATA_W-1:0]        acc_mag;
    logic [DIVN_W-1:0]        dividend;
    logic [DIVN_W-1:0]        quot;
    logic [DATA_W-1:0]        soff_sat;
    logic [ROOT_W-1:0]        root;
    logic                     div_done, sqrt_done;
    logic                     out_load;

    // Matrix addresses
    assign addr_a = AW'(int'(cmd.a_row) * MAX_SIZE + int'(cmd.a_col));
    assign addr_b = AW'(int'(cmd.b_row) * MAX_SIZE + int'(cmd.b_col));

    // Select write word
    always_comb
    begin
        we    = 1'b1;
        wdata = '0;
        unique case (cmd.op)
            OP_WR_IN:   wdata = element_value;
            OP_WR_OFF:  wdata = soff_reg;
            OP_WR_DIAG: wdata = DATA_W'(root);
            default:    we = 1'b0;
        endcase
    end

    // Matrix store, overwritten in place by the factor
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr_a] <= wdata;
        if (cmd.rd_en)
        begin
            rd_a_reg <= mem[addr_a];
            rd_b_reg <= mem[addr_b];
        end
    end

    // Shared multiplier and product scaling toward zero
    always_comb
    begin
        mul_a   = (cmd.op == OP_WR_OFF) ? soff_reg : rd_a_reg;
        mul_b   = (cmd.op == OP_WR_OFF) ? soff_reg : rd_b_reg;
        mul_out = mul_a * mul_b;
        rnd     = prod_reg[PROD_W-1] && (prod_reg[FRAC_W-1:0] != '0);
        qprod   = ACC_W'(prod_reg >>> FRAC_W) + ACC_W'(rnd);
    end

    // Saturate the accumulator and form the divider operand
    always_comb
    begin
        if (acc_reg > SAT_HI)
            acc_sat = SAT_HI[DATA_W-1:0];
        else if (acc_reg < SAT_LO)
            acc_sat = SAT_LO[DATA_W-1:0];
        else
            acc_sat = acc_reg[DATA_W-1:0];
        acc_mag  = acc_sat[DATA_W-1] ? (~acc_sat + 1'b1) : acc_sat;
        dividend = {acc_mag, {FRAC_W{1'b0}}};
    end

    // Apply sign to the quotient and saturate
    always_comb
    begin
        if (neg_reg)
            soff_sat = (quot > Q_NEG_MAX) ? W_MIN : (~quot[DATA_W-1:0] + 1'b1);
        else
            soff_sat = (quot > Q_POS_MAX) ? W_MAX : quot[DATA_W-1:0];
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_PIV_LD:
                piv_reg <= ACC_W'(rd_a_reg);
            OP_ACC_LD:
            begin
                acc_reg  <= ACC_W'(rd_a_reg);
                diag_reg <= rd_b_reg[DIVD_W-1:0];
            end
            OP_MUL:
                prod_reg <= mul_out;
            OP_ACC_SUB:
                acc_reg <= acc_reg - qprod;
            OP_DIV_GO:
                neg_reg <= acc_sat[DATA_W-1];
            OP_DIV_TAKE:
                soff_reg <= soff_sat;
            OP_WR_OFF:
                prod_reg <= mul_out;
            OP_PIV_SUB:
                piv_reg <= piv_reg - qprod;
            default:
            begin
            end
        endcase
    end

    chol_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == OP_DIV_GO),
        .dividend (dividend),
        .divisor  (diag_reg),
        .done     (div_done),
        .quot     (quot)
    );

    chol_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == OP_SQRT_GO),
        .radicand ({piv_reg[DATA_W-1:0], {FRAC_W{1'b0}}}),
        .done     (sqrt_done),
        .root     (root)
    );

    // Output word register
    assign out_load = (cmd.op == OP_OUT_DATA) || (cmd.op == OP_OUT_ERR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if ((cmd.op == OP_OUT_ERR) || (cmd.a_col < cmd.a_row))
                factor_reg <= '0;
            else
                factor_reg <= rd_a_reg;
            row_reg    <= cmd.a_row;
            col_reg    <= cmd.a_col;
            status_reg <= cmd.status;
            last_reg   <= cmd.last;
        end
    end

    // Status back to the controller
    always_comb
    begin
        sts.div_done   = div_done;
        sts.sqrt_done  = sqrt_done;
        sts.sym_diff   = rd_a_reg != rd_b_reg;
        sts.piv_nonpos = piv_reg[ACC_W-1] || (piv_reg == '0);
        sts.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid    = out_valid_reg;
    assign factor_value = factor_reg;
    assign out_row      = row_reg;
    assign out_col      = col_reg;
    assign status       = status_reg;
    assign last_result  = last_reg;

`ifndef SYNTHESIS
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ready))
        else $error("output word overwritten while held");

    a_div_pivot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_DIV_GO) |-> (diag_reg >= DIVD_W'(1 << (FRAC_W / 2))))
        else $error("divisor below smallest diagonal value");

    a_sqrt_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_SQRT_GO) |-> !sts.piv_nonpos)
        else $error("root started on non-positive pivot");
`endif

endmodule

`default_nettype wire

### hw/rtl/chol_ctrl.sv
`default_nettype none

module chol_ctrl #(
    parameter int MAX_SIZE = chol_pkg::MAX_SIZE_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [chol_pkg::SIZE_W-1:0] cfg_wdata,
    output logic [chol_pkg::SIZE_W-1:0] size,
    input  logic                        in_valid,
    output logic                        in_ready,
    output chol_pkg::cmd_t              cmd,
    input  chol_pkg::sts_t              sts
);
    import chol_pkg::*;

    localparam int SW = 5;
    localparam logic [SW-1:0] S_LOAD     = 5'd0;
    localparam logic [SW-1:0] S_SYM_RD   = 5'd1;
    localparam logic [SW-1:0] S_SYM_CMP  = 5'd2;
    localparam logic [SW-1:0] S_PIV_RD   = 5'd3;
    localparam logic [SW-1:0] S_PIV_LD   = 5'd4;
    localparam logic [SW-1:0] S_ACC_RD   = 5'd5;
    localparam logic [SW-1:0] S_ACC_LD   = 5'd6;
    localparam logic [SW-1:0] S_MUL_RD   = 5'd7;
    localparam logic [SW-1:0] S_MUL      = 5'd8;
    localparam logic [SW-1:0] S_SUB      = 5'd9;
    localparam logic [SW-1:0] S_DIV_GO   = 5'd10;
    localparam logic [SW-1:0] S_DIV_WAIT = 5'd11;
    localparam logic [SW-1:0] S_WR_OFF   = 5'd12;
    localparam logic [SW-1:0] S_PIV_SUB  = 5'd13;
    localparam logic [SW-1:0] S_CHK      = 5'd14;
    localparam logic [SW-1:0] S_SQ_WAIT  = 5'd15;
    localparam logic [SW-1:0] S_ERR      = 5'd16;
    localparam logic [SW-1:0] S_EMIT_RD  = 5'd17;
    localparam logic [SW-1:0] S_EMIT_LD  = 5'd18;

    logic [SW-1:0]     state_reg, state_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [IDX_W-1:0]  lr_reg, lr_next;
    logic [IDX_W-1:0]  lc_reg, lc_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [STAT_W-1:0] err_reg, err_next;

    logic [IDX_W-1:0] nm1;
    logic             accept;

    // Clamp the configured size to last index
    always_comb
    begin
        if (size_reg == '0)
            nm1 = '0;
        else if (int'(size_reg) > MAX_SIZE)
            nm1 = IDX_W'(MAX_SIZE - 1);
        else
            nm1 = IDX_W'(size_reg - 1'b1);
    end

    assign in_ready = (state_reg == S_LOAD);
    assign accept   = in_valid && in_ready;

    // Sequence loading, checking, factoring and emission
    always_comb
    begin
        state_next = state_reg;
        size_next  = size_reg;
        lr_next    = lr_reg;
        lc_next    = lc_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        err_next   = err_reg;
        cmd        = '0;
        cmd.op     = OP_NONE;
        cmd.status = ST_OK;

        unique case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    cmd.op    = OP_WR_IN;
                    cmd.a_row = lr_reg;
                    cmd.a_col = lc_reg;
                    if (lc_reg == nm1)
                    begin
                        lc_next = '0;
                        if (lr_reg == nm1)
                        begin
                            lr_next = '0;
                            i_next  = '0;
                            if (nm1 == '0)
                            begin
                                j_next     = '0;
                                state_next = S_PIV_RD;
                            end
                            else
                            begin
                                j_next     = IDX_W'(1);
                                state_next = S_SYM_RD;
                            end
                        end
                        else
                            lr_next = lr_reg + 1'b1;
                    end
                    else
                        lc_next = lc_reg + 1'b1;
                end
            end
            S_SYM_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.a_row  = i_reg;
                cmd.a_col  = j_reg;
                cmd.b_row  = j_reg;
                cmd.b_col  = i_reg;
                state_next = S_SYM_CMP;
            end
            S_SYM_CMP:
            begin
                if (sts.sym_diff)
                begin
                    err_next   = ST_NOT_SYM;
                    state_next = S_ERR;
                end
                else if (j_reg == nm1)
                begin
                    if (i_reg + 1'b1 == nm1)
                    begin
                        j_next     = '0;
                        state_next = S_PIV_RD;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        j_next     = i_reg + 2'd2;
                        state_next = S_SYM_RD;
                    end
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_SYM_RD;
                end
            end
            S_PIV_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.a_row  = j_reg;
                cmd.a_col  = j_reg;
                i_next     = '0;
                state_next = S_PIV_LD;
            end
            S_PIV_LD:
            begin
                cmd.op     = OP_PIV_LD;
                state_next = (j_reg == '0) ? S_CHK : S_ACC_RD;
            end
            S_ACC_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.a_row  = i_reg;
                cmd.a_col  = j_reg;
                cmd.b_row  = i_reg;
                cmd.b_col  = i_reg;
                k_next     = '0;
                state_next = S_ACC_LD;
            end
            S_ACC_LD:
            begin
                cmd.op     = OP_ACC_LD;
                state_next = (i_reg == '0) ? S_DIV_GO : S_MUL_RD;
            end
            S_MUL_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.a_row  = k_reg;
                cmd.a_col  = i_reg;
                cmd.b_row  = k_reg;
                cmd.b_col  = j_reg;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.op     = OP_MUL;
                state_next = S_SUB;
            end
            S_SUB:
            begin
                cmd.op = OP_ACC_SUB;
                if (k_reg + 1'b1 == i_reg)
                    state_next = S_DIV_GO;
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_MUL_RD;
                end
            end
            S_DIV_GO:
            begin
                cmd.op     = OP_DIV_GO;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.op     = OP_DIV_TAKE;
                    state_next = S_WR_OFF;
                end
            end
            S_WR_OFF:
            begin
                cmd.op     = OP_WR_OFF;
                cmd.a_row  = i_reg;
                cmd.a_col  = j_reg;
                state_next = S_PIV_SUB;
            end
            S_PIV_SUB:
            begin
                cmd.op = OP_PIV_SUB;
                if (i_reg + 1'b1 == j_reg)
                    state_next = S_CHK;
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_ACC_RD;
                end
            end
            S_CHK:
            begin
                if (sts.piv_nonpos)
                begin
                    err_next   = ST_NOT_PD;
                    state_next = S_ERR;
                end
                else
                begin
                    cmd.op     = OP_SQRT_GO;
                    state_next = S_SQ_WAIT;
                end
            end
            S_SQ_WAIT:
            begin
                if (sts.sqrt_done)
                begin
                    cmd.op    = OP_WR_DIAG;
                    cmd.a_row = j_reg;
                    cmd.a_col = j_reg;
                    if (j_reg == nm1)
                    begin
                        i_next     = '0;
                        j_next     = '0;
                        state_next = S_EMIT_RD;
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = S_PIV_RD;
                    end
                end
            end
            S_ERR:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_OUT_ERR;
                    cmd.status = err_reg;
                    cmd.last   = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_EMIT_RD:
            begin
                if (sts.out_free)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.a_row  = i_reg;
                    cmd.a_col  = j_reg;
                    state_next = S_EMIT_LD;
                end
            end
            S_EMIT_LD:
            begin
                cmd.op     = OP_OUT_DATA;
                cmd.a_row  = i_reg;
                cmd.a_col  = j_reg;
                cmd.last   = (i_reg == nm1) && (j_reg == nm1);
                state_next = S_EMIT_RD;
                if (j_reg == nm1)
                begin
                    j_next = '0;
                    if (i_reg == nm1)
                    begin
                        i_next     = '0;
                        state_next = S_LOAD;
                    end
                    else
                        i_next = i_reg + 1'b1;
                end
                else
                    j_next = j_reg + 1'b1;
            end
            default:
                state_next = S_LOAD;
        endcase

        // Size write drops any partial matrix
        if (cfg_we)
        begin
            size_next = cfg_wdata;
            lr_next   = '0;
            lc_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            size_reg  <= SIZE_RESET;
            lr_reg    <= '0;
            lc_reg    <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            err_reg   <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            size_reg  <= size_next;
            lr_reg    <= lr_next;
            lc_reg    <= lc_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            err_reg   <= err_next;
        end
    end

    assign size = size_reg;

`ifndef SYNTHESIS
    a_mul_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL_RD) |-> ((k_reg < i_reg) && (i_reg < j_reg)))
        else $error("update term outside upper triangle");

    a_off_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR_OFF) |-> ((i_reg < j_reg) && (j_reg <= nm1)))
        else $error("off-diagonal write outside matrix");

    a_load_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> ((lr_reg <= nm1) && (lc_reg <= nm1)))
        else $error("load position outside matrix");
`endif

endmodule

`default_nettype wire

### hw/rtl/cholesky_decomposition.sv
`default_nettype none

// Cholesky factoriser for a symmetric matrix of up to MAX_SIZE x MAX_SIZE signed
// Q16.16 words. Write matrix_size at address 0, then stream the matrix row-major,
// one word per cycle on the input channel. After the last word the block checks
// symmetry, then factors column by column in place in the matrix store, using one
// shared 32x32 multiplier for the update terms, a restoring divider for each
// off-diagonal term and a digit-serial root for each pivot. The result is S row-major
// with zeros below the diagonal, or one error word (status 1 not symmetric, 2 not
// positive definite) with last_result set. The input is refused from the last word
// of a matrix until its last result sits in the output register.

module cholesky_decomposition #(
    parameter int MAX_SIZE = chol_pkg::MAX_SIZE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [chol_pkg::PADDR_W-1:0]       paddr,
    input  logic [chol_pkg::DATA_W-1:0]        pwdata,
    output logic [chol_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [chol_pkg::DATA_W-1:0] element_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [chol_pkg::DATA_W-1:0] factor_value,
    output logic [chol_pkg::IDX_W-1:0]         out_row,
    output logic [chol_pkg::IDX_W-1:0]         out_col,
    output logic [chol_pkg::STAT_W-1:0]        status,
    output logic                               last_result
);
    import chol_pkg::*;

    cmd_t              cmd;
    sts_t              sts;
    logic              cfg_we;
    logic              reg_sel;
    logic [SIZE_W-1:0] size;

    // Decode register access
    assign pready  = 1'b1;
    assign reg_sel = paddr[PADDR_W-1:2] == REG_MATRIX_SIZE;
    assign cfg_we  = psel && penable && pwrite && pready && reg_sel;

    always_comb
    begin
        if (reg_sel)
            prdata = {{(DATA_W - SIZE_W){1'b0}}, size};
        else
            prdata = '0;
    end

    chol_ctrl #(
        .MAX_SIZE (MAX_SIZE)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (pwdata[SIZE_W-1:0]),
        .size      (size),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    chol_dp #(
        .MAX_SIZE (MAX_SIZE)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .element_value (element_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .factor_value  (factor_value),
        .out_row       (out_row),
        .out_col       (out_col),
        .status        (status),
        .last_result   (last_result)
    );

endmodule

`default_nettype wire
